// ===== design/asbv_pkg.sv =====
package asbv_pkg;

	localparam int unsigned POS_W = 9;
	localparam int unsigned REC_W = 6;

	localparam logic [POS_W-1:0] POS_VERSION_END = 9'd5;
	localparam logic [POS_W-1:0] POS_HDRSIZE_END = 9'd7;
	localparam logic [POS_W-1:0] POS_PAYSIZE_END = 9'd11;
	localparam logic [POS_W-1:0] POS_HDR_LAST    = 9'd15;
	localparam logic [POS_W-1:0] POS_HDR_BYTES   = 9'd16;
	localparam logic [POS_W-1:0] POS_CHAN_END    = 9'd244;
	localparam logic [POS_W-1:0] POS_VOL0_END    = 9'd247;
	localparam logic [POS_W-1:0] POS_VOL1_END    = 9'd251;
	localparam logic [POS_W-1:0] POS_LAST        = 9'd303;
	localparam logic [POS_W-1:0] POS_FULL        = 9'd304;

	localparam logic [REC_W-1:0] REC_LAST = 6'd56;

	localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME     = 32'd16777619;
	localparam logic [31:0] PAYLOAD_BYTES = 32'd288;
	localparam logic [15:0] VERSION_ONE   = 16'd1;
	localparam logic [15:0] HDR_SIZE      = 16'd16;

	localparam logic [31:0] LEVEL_MIN_RESET = 32'hFFFF_F000;
	localparam logic [31:0] LEVEL_MAX_RESET = 32'd4095;

	localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h47, 8'h41, 8'h50};

	localparam logic REG_LEVEL_MIN = 1'b0;
	localparam logic REG_LEVEL_MAX = 1'b1;

	typedef enum logic [3:0] {
		ERR_NONE,
		ERR_LENGTH,
		ERR_MAGIC,
		ERR_VERSION,
		ERR_HDR_SIZE,
		ERR_PAY_SIZE,
		ERR_CHECKSUM,
		ERR_CHANNEL,
		ERR_MASTER_VOL,
		ERR_PHASE
	} err_code_t;

	typedef struct packed {
		logic      fail;
		err_code_t code;
		logic [1:0] chan;
	} byte_check_t;

	typedef struct packed {
		logic       ok;
		err_code_t  code;
		logic [1:0] chan;
		logic [21:0] phase;
	} verdict_t;

endpackage

// ===== design/asbv_field_check.sv =====
module asbv_field_check (
	input  logic [asbv_pkg::POS_W-1:0] pos,
	input  logic [1:0]                 ch,
	input  logic [asbv_pkg::REC_W-1:0] rec,
	input  logic [7:0]                 data,
	input  logic [31:0]                field,
	input  logic [31:0]                level_min,
	input  logic [31:0]                level_max,
	output asbv_pkg::byte_check_t      check
);
	import asbv_pkg::*;

	logic rec_ok;
	logic level_in_range;
	logic [15:0] upper;

	assign upper = field[31:16];
	assign level_in_range = ($signed(field) >= $signed(level_min)) &&
		($signed(field) <= $signed(level_max));

	always_comb begin
		case (rec)
			6'd0, 6'd1, 6'd2, 6'd3: rec_ok = data <= 8'd1;
			6'd4, 6'd5: rec_ok = (ch == 2'd2) ? (data <= 8'd3) : (data <= 8'd15);
			6'd7: rec_ok = (ch == 2'd3) || (upper <= 16'd2047);
			6'd19: rec_ok = (ch == 2'd2) ? (field <= 32'd31) : level_in_range;
			6'd20: rec_ok = (ch == 2'd2) || (data <= 8'd63);
			6'd21: rec_ok = (data == 8'h00) || (data == 8'h40);
			6'd30, 6'd40, 6'd41: rec_ok = data <= 8'd7;
			6'd31, 6'd42: rec_ok = (data == 8'h00) || (data == 8'h08);
			6'd53: rec_ok = (ch != 2'd2) || (data <= 8'd15);
			6'd54: rec_ok = (ch >= 2'd2) || (data <= 8'd7);
			6'd55: rec_ok = (ch != 2'd3) || (data <= 8'd1);
			6'd56: rec_ok = (ch != 2'd3) || (data <= 8'd7);
			default: rec_ok = 1'b1;
		endcase
	end

	always_comb begin
		check = '{fail: 1'b0, code: ERR_NONE, chan: 2'd0};
		if (pos < 9'd4) begin
			if (data != MAGIC[pos[1:0]]) begin
				check.fail = 1'b1;
				check.code = ERR_MAGIC;
			end
		end else if (pos == POS_VERSION_END) begin
			if (upper != VERSION_ONE) begin
				check.fail = 1'b1;
				check.code = ERR_VERSION;
			end
		end else if (pos == POS_HDRSIZE_END) begin
			if (upper != HDR_SIZE) begin
				check.fail = 1'b1;
				check.code = ERR_HDR_SIZE;
			end
		end else if (pos == POS_PAYSIZE_END) begin
			if (field != PAYLOAD_BYTES) begin
				check.fail = 1'b1;
				check.code = ERR_PAY_SIZE;
			end
		end else if (pos >= POS_HDR_BYTES && pos < POS_CHAN_END) begin
			if (!rec_ok) begin
				check.fail = 1'b1;
				check.code = ERR_CHANNEL;
				check.chan = ch;
			end
		end else if (pos == POS_VOL0_END || pos == POS_VOL1_END) begin
			if (field > 32'd7) begin
				check.fail = 1'b1;
				check.code = ERR_MASTER_VOL;
			end
		end else if (pos == POS_LAST) begin
			if (field[31:22] != 10'd0) begin
				check.fail = 1'b1;
				check.code = ERR_PHASE;
			end
		end
	end

endmodule

// ===== design/asbv_stream.sv =====
module asbv_stream (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data,
	input  logic              last,
	input  logic [31:0]       level_min,
	input  logic [31:0]       level_max,
	output asbv_pkg::verdict_t verdict
);
	import asbv_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [1:0]       ch_q;
	logic [REC_W-1:0] rec_q;
	logic [31:0]      hash_q;
	logic [31:0]      field_q;
	logic [31:0]      stored_q;
	err_code_t        first_err_q;
	logic [1:0]       fail_ch_q;

	logic [POS_W-1:0] pos_next;
	logic [1:0]       ch_next;
	logic [REC_W-1:0] rec_next;
	logic [31:0]      hash_next;
	logic [31:0]      hash_mul;
	logic [31:0]      field_new;
	logic [31:0]      field_next;
	logic [31:0]      stored_next;
	err_code_t        first_err_next;
	logic [1:0]       fail_ch_next;
	logic             in_range;
	byte_check_t      check;
	err_code_t        code;

	assign in_range  = pos_q < POS_FULL;
	assign field_new = {data, field_q[31:8]};
	assign hash_mul  = (hash_q ^ {24'd0, data}) * FNV_PRIME;

	asbv_field_check u_check (
		.pos       (pos_q),
		.ch        (ch_q),
		.rec       (rec_q),
		.data      (data),
		.field     (field_new),
		.level_min (level_min),
		.level_max (level_max),
		.check     (check)
	);

	always_comb begin
		pos_next       = pos_q;
		ch_next        = ch_q;
		rec_next       = rec_q;
		hash_next      = hash_q;
		field_next     = field_q;
		stored_next    = stored_q;
		first_err_next = first_err_q;
		fail_ch_next   = fail_ch_q;
		if (in_range) begin
			pos_next   = pos_q + 9'd1;
			field_next = field_new;
			if (pos_q >= POS_HDR_BYTES) begin
				hash_next = hash_mul;
			end
			if (pos_q == POS_HDR_LAST) begin
				stored_next = field_new;
				ch_next     = 2'd0;
				rec_next    = '0;
			end else if (pos_q >= POS_HDR_BYTES && pos_q < POS_CHAN_END) begin
				if (rec_q == REC_LAST) begin
					rec_next = '0;
					ch_next  = ch_q + 2'd1;
				end else begin
					rec_next = rec_q + 6'd1;
				end
			end
			if (first_err_q == ERR_NONE && check.fail) begin
				first_err_next = check.code;
				fail_ch_next   = check.chan;
			end
		end
	end

	always_comb begin
		if (pos_q != POS_LAST) begin
			code = ERR_LENGTH;
		end else if (first_err_next == ERR_MAGIC || first_err_next == ERR_VERSION ||
			first_err_next == ERR_HDR_SIZE || first_err_next == ERR_PAY_SIZE) begin
			code = first_err_next;
		end else if (hash_next != stored_q) begin
			code = ERR_CHECKSUM;
		end else begin
			code = first_err_next;
		end
		verdict.ok    = code == ERR_NONE;
		verdict.code  = code;
		verdict.chan  = (code == ERR_CHANNEL) ? fail_ch_next : 2'd0;
		verdict.phase = (code == ERR_NONE) ? field_new[21:0] : 22'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			ch_q        <= 2'd0;
			rec_q       <= '0;
			hash_q      <= FNV_BASIS;
			field_q     <= '0;
			stored_q    <= '0;
			first_err_q <= ERR_NONE;
			fail_ch_q   <= 2'd0;
		end else if (step) begin
			if (last) begin
				pos_q       <= '0;
				ch_q        <= 2'd0;
				rec_q       <= '0;
				hash_q      <= FNV_BASIS;
				field_q     <= '0;
				stored_q    <= '0;
				first_err_q <= ERR_NONE;
				fail_ch_q   <= 2'd0;
			end else begin
				pos_q       <= pos_next;
				ch_q        <= ch_next;
				rec_q       <= rec_next;
				hash_q      <= hash_next;
				field_q     <= field_next;
				stored_q    <= stored_next;
				first_err_q <= first_err_next;
				fail_ch_q   <= fail_ch_next;
			end
		end
	end

endmodule

// ===== design/apu_state_blob_validator.sv =====
// Streams a save-state blob in one byte per cycle while not stalled and checks it on the fly.
// Each byte request is registered, then hashed and checked from that input register.
// The verdict is registered: the last byte passes the input register, then the result register.
// Throughput is one byte per cycle while in_stall is low, with a new request accepted at every unstalled edge.
// The input stalls only while a verdict is held at the output and the next last byte waits.
// Asynchronous active-low reset clears the stream state and valid flags and restores the level limits.
module apu_state_blob_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        blob_ok,
	output logic [3:0]  error_code,
	output logic [1:0]  bad_channel,
	output logic [21:0] frame_phase,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import asbv_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        step;
	logic        out_valid_q;
	logic [31:0] level_min_q;
	logic [31:0] level_max_q;
	verdict_t    verdict;
	verdict_t    result_q;

	assign advance  = !(last_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_min_q <= LEVEL_MIN_RESET;
			level_max_q <= LEVEL_MAX_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_LEVEL_MIN) begin
				level_min_q <= cfg_data;
			end else begin
				level_max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	asbv_stream u_stream (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data      (byte_s1),
		.last      (last_s1),
		.level_min (level_min_q),
		.level_max (level_max_q),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= verdict;
		end
	end

	assign out_valid    = out_valid_q;
	assign blob_ok      = result_q.ok;
	assign error_code   = result_q.code;
	assign bad_channel  = result_q.chan;
	assign frame_phase  = result_q.phase;

endmodule
